// ===== rtl/bat_pkg.sv =====
// Shared types and constants for the breakpoint address table.
// No dependencies; every other file in rtl/ imports this package.
`timescale 1ns / 1ps

package bat_pkg;

  localparam int ADDR_W  = 64;  // width of an instruction address
  localparam int WORD_W  = 62;  // stored address bits 63..2
  localparam int LIMIT_W = 5;   // width of the max_entries register
  localparam int COUNT_W = 5;   // width of the reported entry count

  localparam logic [LIMIT_W-1:0] LIMIT_RESET = 5'd16;

  typedef enum logic [1:0] {
    CMD_ADD    = 2'd0,
    CMD_REMOVE = 2'd1,
    CMD_CLEAR  = 2'd2,
    CMD_MATCH  = 2'd3
  } cmd_t;

endpackage

// ===== rtl/bat_if.sv =====
// Handshake channel interfaces for the breakpoint address table.
// Depends on bat_pkg for the command type and the field widths.
`timescale 1ns / 1ps

// Command channel: one command and one address per transaction.
interface bat_req_if import bat_pkg::*; ();
  logic              valid;
  logic              ready;
  cmd_t              command;
  logic [ADDR_W-1:0] address;

  modport source (output valid, output command, output address, input ready);
  modport sink   (input valid, input command, input address, output ready);
endinterface

// Result channel: one result per command.
interface bat_rsp_if import bat_pkg::*; ();
  logic               valid;
  logic               ready;
  logic               success;
  logic [COUNT_W-1:0] entry_count;

  modport source (output valid, output success, output entry_count, input ready);
  modport sink   (input valid, input success, input entry_count, output ready);
endinterface

// Configuration channel: writes the max_entries register.
interface bat_cfg_if import bat_pkg::*; ();
  logic               valid;
  logic               ready;
  logic [LIMIT_W-1:0] data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

// ===== rtl/bat_mem.sv =====
// Address store of the breakpoint table: one write port, one read port,
// read data registered. Depends on bat_pkg for the word width.
`timescale 1ns / 1ps

module bat_mem import bat_pkg::*; #(
  parameter int DEPTH = 16,
  parameter int AW    = 4
) (
  input  logic              clk,
  input  logic              we,
  input  logic [AW-1:0]     waddr,
  input  logic [WORD_W-1:0] wdata,
  input  logic [AW-1:0]     raddr,
  output logic [WORD_W-1:0] rdata
);

  logic [WORD_W-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule

// ===== rtl/bat_ctrl.sv =====
// Command sequencer of the breakpoint table: scans the address store,
// appends, moves the last entry into a hole, and registers the result.
// Depends on bat_pkg and the channel interfaces in bat_if.sv.
`timescale 1ns / 1ps

module bat_ctrl import bat_pkg::*; #(
  parameter int TABLE_SLOTS = 16,
  parameter int AW          = 4,
  parameter int CW          = 5
) (
  input  logic               clk,
  input  logic               rst,
  input  logic [LIMIT_W-1:0] max_entries,
  bat_req_if.sink            req,
  bat_rsp_if.source          rsp,
  output logic               mem_we,
  output logic [AW-1:0]      mem_waddr,
  output logic [WORD_W-1:0]  mem_wdata,
  output logic [AW-1:0]      mem_raddr,
  input  logic [WORD_W-1:0]  mem_rdata
);

  localparam int LW = (CW > LIMIT_W) ? CW : LIMIT_W;

  typedef enum logic [2:0] {
    S_IDLE,
    S_SCAN,
    S_LAST,
    S_MOVE,
    S_DONE
  } state_t;

  state_t              state;
  cmd_t                cmd_q;
  logic [WORD_W-1:0]   word_q;
  logic [CW-1:0]       count;
  logic [CW-1:0]       idx;
  logic                pend;
  logic [AW-1:0]       pend_idx;
  logic [AW-1:0]       hit_idx;
  logic                ok;
  logic                rsp_valid;
  logic                rsp_success;
  logic [COUNT_W-1:0]  rsp_count;

  logic                room;
  logic                pend_hit;
  logic [CW-1:0]       last_idx;
  logic                add_write;

  // An add has room when the count is below both the register and the slots.
  assign room = (LW'(count) < LW'(max_entries)) && (count < CW'(TABLE_SLOTS));
  assign pend_hit = pend && (mem_rdata == word_q);
  assign last_idx = count - CW'(1);

  // The scan has ended without a hit and an add appends its address.
  assign add_write = (state == S_SCAN) && !pend_hit && !(idx < count) &&
                     (cmd_q == CMD_ADD) && room;

  assign req.ready       = (state == S_IDLE);
  assign rsp.valid       = rsp_valid;
  assign rsp.success     = rsp_success;
  assign rsp.entry_count = rsp_count;

  always_comb begin
    if (state == S_LAST) begin
      mem_raddr = last_idx[AW-1:0];
    end else begin
      mem_raddr = idx[AW-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      count     <= '0;
      pend      <= 1'b0;
      rsp_valid <= 1'b0;
      mem_we    <= 1'b0;
    end else begin
      mem_we <= add_write || (state == S_MOVE);
      if (state == S_DONE && (!rsp_valid || rsp.ready)) begin
        rsp_valid <= 1'b1;
      end else if (rsp_valid && rsp.ready) begin
        rsp_valid <= 1'b0;
      end

      case (state)
        S_IDLE: begin
          if (req.valid) begin
            cmd_q  <= req.command;
            word_q <= req.address[ADDR_W-1:2];
            idx    <= '0;
            pend   <= 1'b0;
            if (req.command == CMD_CLEAR) begin
              count <= '0;
              ok    <= 1'b1;
              state <= S_DONE;
            end else begin
              state <= S_SCAN;
            end
          end
        end

        // One read issued per cycle; the previous read is compared meanwhile.
        S_SCAN: begin
          if (pend_hit) begin
            pend    <= 1'b0;
            hit_idx <= pend_idx;
            case (cmd_q)
              CMD_REMOVE: begin
                ok    <= 1'b0;
                state <= S_LAST;
              end
              CMD_MATCH: begin
                ok    <= 1'b1;
                state <= S_DONE;
              end
              default: begin
                ok    <= 1'b0;
                state <= S_DONE;
              end
            endcase
          end else if (idx < count) begin
            pend     <= 1'b1;
            pend_idx <= idx[AW-1:0];
            idx      <= idx + CW'(1);
          end else begin
            pend <= 1'b0;
            if (add_write) begin
              mem_waddr <= count[AW-1:0];
              mem_wdata <= word_q;
              count     <= count + CW'(1);
              ok        <= 1'b1;
            end else begin
              ok <= 1'b0;
            end
            state <= S_DONE;
          end
        end

        // Read of the last live entry is in flight.
        S_LAST: begin
          state <= S_MOVE;
        end

        // The last entry fills the hole left by the removed one.
        S_MOVE: begin
          mem_waddr <= hit_idx;
          mem_wdata <= mem_rdata;
          count     <= last_idx;
          ok        <= 1'b1;
          state     <= S_DONE;
        end

        S_DONE: begin
          if (!rsp_valid || rsp.ready) begin
            rsp_success <= ok;
            rsp_count   <= COUNT_W'(count);
            state       <= S_IDLE;
          end
        end

        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule

// ===== rtl/breakpoint_address_table.sv =====
// Breakpoint address table: holds up to TABLE_SLOTS word-aligned breakpoint
// addresses and runs add, remove, clear and match commands, one result each.
// Depends on bat_pkg, the interfaces in bat_if.sv, bat_mem and bat_ctrl.
`timescale 1ns / 1ps

// The table keeps address bits 63..2 of each breakpoint in a one-port-write,
// one-port-read memory and a live count; bits 1..0 of every command address
// are ignored. Add fails on a duplicate or when the count has reached the
// lesser of max_entries and TABLE_SLOTS; remove fails if the address is
// absent and otherwise moves the last live entry into the freed slot; clear
// always succeeds; match succeeds on a hit. entry_count reports the count
// after the command (low five bits). Commands are handled one at a time; the
// search reads one entry per clock from the memory, a hit ends it early, and
// a clear skips it. The command channel is ready again as soon as a
// result is loaded into the output register, even if that result has not
// been taken yet. max_entries resets to 16 and is written through the cfg
// channel, which is always ready; write it only while no command is in
// progress. The memory needs no clearing after reset because only entries
// below the live count are ever read.

module breakpoint_address_table import bat_pkg::*; #(
  parameter int TABLE_SLOTS = 16
) (
  input  logic      clk,
  input  logic      rst,
  bat_cfg_if.sink   cfg,
  bat_req_if.sink   req,
  bat_rsp_if.source rsp
);

  // Memory address width and count width (the count can reach TABLE_SLOTS).
  localparam int AW = (TABLE_SLOTS > 1) ? $clog2(TABLE_SLOTS) : 1;
  localparam int CW = $clog2(TABLE_SLOTS + 1);

  logic [LIMIT_W-1:0] max_entries;

  logic               mem_we;
  logic [AW-1:0]      mem_waddr;
  logic [WORD_W-1:0]  mem_wdata;
  logic [AW-1:0]      mem_raddr;
  logic [WORD_W-1:0]  mem_rdata;

  // The configuration register takes a write on every cfg transaction.
  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      max_entries <= LIMIT_RESET;
    end else if (cfg.valid) begin
      max_entries <= cfg.data;
    end
  end

  // Address store. Writes from the sequencer land in the cycle after the
  // decision, well before any later command can read the same slot.
  bat_mem #(
    .DEPTH (TABLE_SLOTS),
    .AW    (AW)
  ) u_mem (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

  // Command sequencer with the live count and the result register.
  bat_ctrl #(
    .TABLE_SLOTS (TABLE_SLOTS),
    .AW          (AW),
    .CW          (CW)
  ) u_ctrl (
    .clk         (clk),
    .rst         (rst),
    .max_entries (max_entries),
    .req         (req),
    .rsp         (rsp),
    .mem_we      (mem_we),
    .mem_waddr   (mem_waddr),
    .mem_wdata   (mem_wdata),
    .mem_raddr   (mem_raddr),
    .mem_rdata   (mem_rdata)
  );

endmodule

// ===== tb/testbench.sv =====
// Self-checking testbench for breakpoint_address_table: directed and random command traffic.
// It predicts every result with a scoreboard class. It depends on bat_pkg, the channel
// interfaces in bat_if.sv and the RTL top level.
`timescale 1ns / 1ps

module testbench;
  import bat_pkg::*;

  localparam int TABLE_SLOTS     = 16;
  localparam int POOL_SIZE       = 24;      // addresses that random traffic keeps reusing
  localparam int PHASE_COUNT     = 9;
  localparam int ITEMS_PER_PHASE = 150;
  localparam int SETTLE_CYCLES   = 40;      // well above the slowest command
  localparam int CYCLE_LIMIT     = 750000;  // several times the slowest correct run
  localparam int SLOT_AW         = $clog2(TABLE_SLOTS);
  localparam int POOL_AW         = $clog2(POOL_SIZE);
  localparam int PHASE_AW        = $clog2(PHASE_COUNT);

  // One expected result: the outcome of a command and the count that follows it.
  typedef struct packed {
    logic               success;
    logic [COUNT_W-1:0] entry_count;
  } table_result_t;

  // The scoreboard keeps its own copy of the breakpoint table. Each accepted command
  // updates the copy and queues the result that the block must return for it. Each
  // result that the block returns is checked against the oldest queued entry.
  class breakpoint_tracker;
    logic [WORD_W-1:0] slot_words [TABLE_SLOTS];
    int unsigned       live;
    int unsigned       limit;
    table_result_t     expected_results [$];
    int                errors;
    int                checked;
    int                adds_taken;
    int                removes_taken;
    int                match_hits;

    function new();
      live          = 0;
      limit         = 32'(LIMIT_RESET);
      errors        = 0;
      checked       = 0;
      adds_taken    = 0;
      removes_taken = 0;
      match_hits    = 0;
    endfunction

    function void set_limit(logic [LIMIT_W-1:0] value);
      limit = 32'(value);
    endfunction

    function int unsigned pending();
      return expected_results.size();
    endfunction

    // Returns the slot that holds word, or TABLE_SLOTS when no live slot holds it.
    function int unsigned find_word(logic [WORD_W-1:0] word);
      for (int unsigned i = 0; i < live && i < TABLE_SLOTS; i++) begin
        if (slot_words[SLOT_AW'(i)] == word) return i;
      end
      return TABLE_SLOTS;
    endfunction

    function void note_command(cmd_t command, logic [ADDR_W-1:0] address);
      logic [WORD_W-1:0] word;
      int unsigned       pos;
      int unsigned       usable;
      table_result_t     predicted;
      word   = address[ADDR_W-1:2];
      usable = (limit < TABLE_SLOTS) ? limit : TABLE_SLOTS;
      predicted.success = 1'b0;
      case (command)
        CMD_ADD: begin
          if (find_word(word) == TABLE_SLOTS && live < usable) begin
            slot_words[SLOT_AW'(live)] = word;
            live++;
            predicted.success = 1'b1;
            adds_taken++;
          end
        end
        CMD_REMOVE: begin
          pos = find_word(word);
          if (pos < TABLE_SLOTS && live > 0 && live <= TABLE_SLOTS) begin
            slot_words[SLOT_AW'(pos)] = slot_words[SLOT_AW'(live-1)];
            live--;
            predicted.success = 1'b1;
            removes_taken++;
          end
        end
        CMD_CLEAR: begin
          live = 0;
          predicted.success = 1'b1;
        end
        default: begin
          predicted.success = (find_word(word) < TABLE_SLOTS);
          if (predicted.success) match_hits++;
        end
      endcase
      predicted.entry_count = COUNT_W'(live);
      expected_results.push_back(predicted);
    endfunction

    function void check_result(logic success, logic [COUNT_W-1:0] entry_count);
      table_result_t oldest;
      if (expected_results.size() == 0) begin
        $error("result with no command waiting: success %0d, entry_count %0d",
               success, entry_count);
        errors++;
        return;
      end
      oldest = expected_results.pop_front();
      checked++;
      if (success !== oldest.success) begin
        $error("success: expected %0d, actual %0d", oldest.success, success);
        errors++;
      end
      if (entry_count !== oldest.entry_count) begin
        $error("entry_count: expected %0d, actual %0d", oldest.entry_count, entry_count);
        errors++;
      end
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst = 1'b1;

  bat_cfg_if limit_bus ();
  bat_req_if cmd_bus ();
  bat_rsp_if result_bus ();

  breakpoint_tracker tracker = new();

  // The pool holds addresses that random traffic reuses, so that adds hit duplicates, the
  // table fills up, and removes and matches find their targets often.
  logic [ADDR_W-1:0] address_pool [POOL_SIZE];

  // While this flag is set, neither side inserts random idle cycles.
  bit quiet_traffic = 1'b0;
  int commands_sent = 0;

  always #5 clk = ~clk;

  breakpoint_address_table #(
    .TABLE_SLOTS(TABLE_SLOTS)
  ) u_top (
    .clk (clk),
    .rst (rst),
    .cfg (limit_bus),
    .req (cmd_bus),
    .rsp (result_bus)
  );

  // Idle time before a command. Most gaps are zero or short, and a few are long.
  function automatic int unsigned pick_gap();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (quiet_traffic || r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // The receiver stalls less often than the sender idles, so results do not pile up.
  function automatic int unsigned pick_stall();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (quiet_traffic || r < 75) return 0;
    if (r < 95) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // Adds, removes and matches are common. A clear is rare, so the table has time to fill.
  function automatic cmd_t pick_command();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 3) return CMD_CLEAR;
    if (r < 38) return CMD_ADD;
    if (r < 62) return CMD_REMOVE;
    return CMD_MATCH;
  endfunction

  // Most addresses come from the pool, with random low bits that the block must ignore.
  // The rest are fresh random addresses that almost always miss.
  function automatic logic [ADDR_W-1:0] pick_address();
    logic [ADDR_W-1:0] base;
    logic [1:0]        low_bits;
    low_bits = 2'($urandom_range(0, 3));
    if ($urandom_range(0, 99) < 85) base = address_pool[POOL_AW'($urandom_range(0, POOL_SIZE-1))];
    else base = {$urandom, $urandom};
    return {base[ADDR_W-1:2], low_bits};
  endfunction

  // Offers one command after gap idle cycles and returns at the edge where it is accepted.
  // Valid is left high, so a command that follows with no gap goes back to back.
  task automatic send_command(cmd_t command, logic [ADDR_W-1:0] address, int unsigned gap);
    if (gap > 0) begin
      cmd_bus.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    cmd_bus.valid   <= 1'b1;
    cmd_bus.command <= command;
    cmd_bus.address <= address;
    @(posedge clk);
    while (!cmd_bus.ready) @(posedge clk);
    tracker.note_command(command, address);
    commands_sent++;
  endtask

  // Stops offering commands and waits until every queued result has been returned.
  task automatic wait_until_drained();
    cmd_bus.valid <= 1'b0;
    while (tracker.pending() != 0) @(posedge clk);
  endtask

  // Every command returns a result. Once the queue is empty the block is idle.
  // A wait is added before the register write as a margin.
  task automatic write_limit(logic [LIMIT_W-1:0] value);
    wait_until_drained();
    repeat (4) @(posedge clk);
    limit_bus.valid <= 1'b1;
    limit_bus.data  <= value;
    @(posedge clk);
    while (!limit_bus.ready) @(posedge clk);
    limit_bus.valid <= 1'b0;
    tracker.set_limit(value);
  endtask

  // Watchdog: a run that outlasts CYCLE_LIMIT has hung and is reported as a failure.
  initial begin
    int cycle_count;
    cycle_count = 0;
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("Test completed with failures");
    $finish;
  end

  // Result side: check every accepted transaction and drop ready at random. Once, after
  // about 600 results, ready is held low without a break. In that time the sender keeps
  // offering commands, so the output register fills and the command channel stalls.
  initial begin
    int unsigned stall_left;
    bit          long_hold_done;
    stall_left     = 0;
    long_hold_done = 1'b0;
    result_bus.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (!rst && result_bus.valid && result_bus.ready) begin
        tracker.check_result(result_bus.success, result_bus.entry_count);
      end
      if (!long_hold_done && tracker.checked >= 600) begin
        long_hold_done = 1'b1;
        stall_left     = 500;
      end else if (stall_left == 0) begin
        stall_left = pick_stall();
      end
      if (stall_left > 0) begin
        result_bus.ready <= 1'b0;
        stall_left--;
      end else begin
        result_bus.ready <= 1'b1;
      end
    end
  end

  // Command side: directed cases first, then random phases, one limit setting per phase.
  initial begin
    logic [LIMIT_W-1:0] phase_limits [PHASE_COUNT];
    cmd_bus.valid   <= 1'b0;
    cmd_bus.command <= CMD_MATCH;
    cmd_bus.address <= '0;
    limit_bus.valid <= 1'b0;
    limit_bus.data  <= '0;
    for (int i = 0; i < POOL_SIZE; i++) address_pool[POOL_AW'(i)] = {$urandom, $urandom};

    // The settings include both extremes of the register (0 and 31), the reset value,
    // and small limits that fall below the count that the previous phase left behind.
    phase_limits = '{5'd31, 5'd0, 5'd4, 5'd16, 5'd1, 5'd0, 5'd9, 5'd16, 5'd16};
    phase_limits[7] = LIMIT_W'($urandom_range(0, 31));

    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed part, with the reset limit of 16. It covers the lowest and highest
    // addresses, a duplicate that differs only in the ignored low bits, a remove of an
    // absent address, a remove whose hole is refilled by the last entry, and a match
    // after a clear.
    send_command(CMD_ADD,    64'h0000_0000_0000_0000, pick_gap());
    send_command(CMD_ADD,    64'hFFFF_FFFF_FFFF_FFFF, pick_gap());
    send_command(CMD_ADD,    64'h0000_0000_0000_0003, pick_gap());
    send_command(CMD_MATCH,  64'hFFFF_FFFF_FFFF_FFFC, pick_gap());
    send_command(CMD_MATCH,  64'h0000_0000_0000_0004, pick_gap());
    send_command(CMD_REMOVE, 64'h0000_0000_0000_0008, pick_gap());
    send_command(CMD_REMOVE, 64'h0000_0000_0000_0001, pick_gap());
    send_command(CMD_MATCH,  64'hFFFF_FFFF_FFFF_FFFE, pick_gap());
    send_command(CMD_CLEAR,  64'hFFFF_FFFF_FFFF_FFFF, pick_gap());
    send_command(CMD_MATCH,  64'hFFFF_FFFF_FFFF_FFFF, pick_gap());

    // Fill all sixteen slots. The seventeenth add must fail because the table is full.
    for (int i = 0; i < TABLE_SLOTS + 1; i++) begin
      send_command(CMD_ADD, 64'hA5A5_0000_0000_0000 + (64'(i) << 4), pick_gap());
    end

    // Random phases. Phase 3 draws no random idle cycles on either side. In phase 5 the
    // sender stops halfway and waits until every result has come back.
    for (int phase = 0; phase < PHASE_COUNT; phase++) begin
      write_limit(phase_limits[PHASE_AW'(phase)]);
      quiet_traffic = (phase == 3);
      for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
        if (phase == 5 && n == ITEMS_PER_PHASE / 2) wait_until_drained();
        send_command(pick_command(), pick_address(), pick_gap());
      end
    end
    quiet_traffic = 1'b0;

    wait_until_drained();
    repeat (SETTLE_CYCLES) @(posedge clk);

    $display("Sent %0d commands over %0d limit settings and checked %0d results.",
             commands_sent, PHASE_COUNT + 1, tracker.checked);
    $display("Accepted %0d adds and %0d removes, with %0d match hits.",
             tracker.adds_taken, tracker.removes_taken, tracker.match_hits);
    if (tracker.errors == 0 && tracker.pending() == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
